### rtl/fpa_pkg.sv
`default_nettype none

package fpa_pkg;

  // Operation codes carried by the kind field.
  typedef logic [3:0] kind_t;

  localparam kind_t KIND_ADD = 4'd0;
  localparam kind_t KIND_SUB = 4'd1;
  localparam kind_t KIND_MUL = 4'd2;
  localparam kind_t KIND_DIV = 4'd3;
  localparam kind_t KIND_MIN = 4'd4;
  localparam kind_t KIND_MAX = 4'd5;
  localparam kind_t KIND_INC = 4'd6;
  localparam kind_t KIND_DEC = 4'd7;
  localparam kind_t KIND_I2F = 4'd8;
  localparam kind_t KIND_F2I = 4'd9;

  // Compare flags that travel with every item.
  typedef struct packed {
    logic less;
    logic equal;
    logic greater;
  } cmp_flags_t;

  // Quotient bits resolved by each divider pipeline stage.
  localparam int DIV_STEPS = 2;

  // Number of divider stages needed for a (DATA_WIDTH + FRAC_BITS)-bit quotient.
  function automatic int div_stages(input int data_width, input int frac_bits);
    return (data_width + frac_bits + DIV_STEPS - 1) / DIV_STEPS;
  endfunction

endpackage

`default_nettype wire

### rtl/fpa_clamp.sv
`default_nettype none

module fpa_clamp #(
  parameter int DATA_WIDTH = 32,
  parameter int MAG_WIDTH  = 41
) (
  input  wire logic                  clk,
  input  wire logic                  neg,
  input  wire logic [MAG_WIDTH-1:0]  mag,
  output logic      [DATA_WIDTH-1:0] value,
  output logic                       sat
);

  // Largest positive magnitude and largest negative magnitude.
  localparam logic [MAG_WIDTH-1:0] POS_LIMIT =
    {{(MAG_WIDTH-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [MAG_WIDTH-1:0] NEG_LIMIT = POS_LIMIT + MAG_WIDTH'(1);

  logic [MAG_WIDTH-1:0]  limit;
  logic                  over;
  logic [DATA_WIDTH-1:0] clipped;

  // Clamp the magnitude to the range of the result's sign.
  always_comb begin
    limit   = neg ? NEG_LIMIT : POS_LIMIT;
    over    = mag > limit;
    clipped = over ? limit[DATA_WIDTH-1:0] : mag[DATA_WIDTH-1:0];
  end

  // Apply the sign and register the result.
  always_ff @(posedge clk) begin
    value <= neg ? (~clipped + 1'b1) : clipped;
    sat   <= over;
  end

endmodule

`default_nettype wire

### rtl/fpa_mul.sv
`default_nettype none

module fpa_mul #(
  parameter int DATA_WIDTH  = 32,
  parameter int FRAC_BITS   = 8,
  parameter int TAIL_STAGES = 18
) (
  input  wire logic                  clk,
  input  wire logic [DATA_WIDTH-1:0] mag_a,
  input  wire logic [DATA_WIDTH-1:0] mag_b,
  input  wire logic                  neg,
  output logic      [DATA_WIDTH-1:0] value,
  output logic                       sat
);

  localparam int HALF   = (DATA_WIDTH + 1) / 2;
  localparam int PP_W   = 2 * HALF;
  localparam int SUM_W  = 4 * HALF;
  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int QM_W   = PROD_W - FRAC_BITS + 1;

  logic [DATA_WIDTH-1:0] ma;
  logic [DATA_WIDTH-1:0] mb;
  logic                  neg_a;
  logic [HALF-1:0]       a_lo, a_hi, b_lo, b_hi;
  logic [PP_W-1:0]       p00, p01, p10, p11;
  logic                  neg_b;
  logic [SUM_W-1:0]      full_sum;
  logic [PROD_W-1:0]     prod;
  logic                  neg_c;
  logic [QM_W-1:0]       qround;
  logic                  neg_d;
  logic [DATA_WIDTH-1:0] clamp_value;
  logic                  clamp_sat;
  logic [DATA_WIDTH-1:0] tail_value [TAIL_STAGES];
  logic                  tail_sat   [TAIL_STAGES];

  // Operand capture.
  always_ff @(posedge clk) begin
    ma    <= mag_a;
    mb    <= mag_b;
    neg_a <= neg;
  end

  // Split each magnitude into two halves for four narrow products.
  always_comb begin
    a_lo = ma[HALF-1:0];
    a_hi = HALF'(ma[DATA_WIDTH-1:HALF]);
    b_lo = mb[HALF-1:0];
    b_hi = HALF'(mb[DATA_WIDTH-1:HALF]);
  end

  // Partial products.
  always_ff @(posedge clk) begin
    p00   <= a_lo * b_lo;
    p01   <= a_lo * b_hi;
    p10   <= a_hi * b_lo;
    p11   <= a_hi * b_hi;
    neg_b <= neg_a;
  end

  // Combine the partial products into the full product.
  always_comb begin
    full_sum = {p11, p00} + (SUM_W'(p01) << HALF) + (SUM_W'(p10) << HALF);
  end

  always_ff @(posedge clk) begin
    prod  <= full_sum[PROD_W-1:0];
    neg_c <= neg_b;
  end

  // Drop the fraction bits, rounding half away from zero on the magnitude.
  always_ff @(posedge clk) begin
    qround <= QM_W'(prod[PROD_W-1:FRAC_BITS]) + QM_W'(prod[FRAC_BITS-1]);
    neg_d  <= neg_c;
  end

  fpa_clamp #(
    .DATA_WIDTH (DATA_WIDTH),
    .MAG_WIDTH  (QM_W)
  ) u_clamp (
    .clk   (clk),
    .neg   (neg_d),
    .mag   (qround),
    .value (clamp_value),
    .sat   (clamp_sat)
  );

  // Delay line that lines the product up with the divider's output.
  always_ff @(posedge clk) begin
    tail_value[0] <= clamp_value;
    tail_sat[0]   <= clamp_sat;
    for (int i = 1; i < TAIL_STAGES; i++) begin
      tail_value[i] <= tail_value[i-1];
      tail_sat[i]   <= tail_sat[i-1];
    end
  end

  assign value = tail_value[TAIL_STAGES-1];
  assign sat   = tail_sat[TAIL_STAGES-1];

endmodule

`default_nettype wire

### rtl/fpa_div.sv
`default_nettype none

module fpa_div #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                  clk,
  input  wire logic [DATA_WIDTH-1:0] mag_a,
  input  wire logic [DATA_WIDTH-1:0] mag_b,
  input  wire logic                  neg,
  output logic      [DATA_WIDTH-1:0] value,
  output logic                       sat
);

  import fpa_pkg::*;

  localparam int STAGES = div_stages(DATA_WIDTH, FRAC_BITS);
  localparam int QW     = STAGES * DIV_STEPS;

  // Per stage: partial remainder, numerator bits still to come shifted
  // against the quotient bits already found, divisor and sign.
  logic [DATA_WIDTH-1:0] rem [STAGES+1];
  logic [QW-1:0]         nq  [STAGES+1];
  logic [DATA_WIDTH-1:0] dvs [STAGES+1];
  logic                  sgn [STAGES+1];
  logic                  round_up;
  logic [QW:0]           qround;
  logic                  neg_r;

  // Entry stage: the numerator is the dividend scaled by the fraction bits.
  always_ff @(posedge clk) begin
    rem[0] <= '0;
    nq[0]  <= QW'({mag_a, {FRAC_BITS{1'b0}}});
    dvs[0] <= mag_b;
    sgn[0] <= neg;
  end

  // Restoring division, DIV_STEPS quotient bits per stage.
  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [DATA_WIDTH-1:0] rem_c;
    logic [QW-1:0]         nq_c;
    logic [DATA_WIDTH:0]   trial;

    always_comb begin
      rem_c = rem[s];
      nq_c  = nq[s];
      trial = '0;
      for (int k = 0; k < DIV_STEPS; k++) begin
        trial = {rem_c, nq_c[QW-1]};
        nq_c  = {nq_c[QW-2:0], 1'b0};
        if (trial >= {1'b0, dvs[s]}) begin
          trial   = trial - {1'b0, dvs[s]};
          nq_c[0] = 1'b1;
        end
        rem_c = trial[DATA_WIDTH-1:0];
      end
    end

    always_ff @(posedge clk) begin
      rem[s+1] <= rem_c;
      nq[s+1]  <= nq_c;
      dvs[s+1] <= dvs[s];
      sgn[s+1] <= sgn[s];
    end
  end

  // Round half away from zero: bump when twice the remainder reaches the divisor.
  assign round_up = {rem[STAGES], 1'b0} >= {1'b0, dvs[STAGES]};

  always_ff @(posedge clk) begin
    qround <= (QW+1)'(nq[STAGES]) + (QW+1)'(round_up);
    neg_r  <= sgn[STAGES];
  end

  fpa_clamp #(
    .DATA_WIDTH (DATA_WIDTH),
    .MAG_WIDTH  (QW+1)
  ) u_clamp (
    .clk   (clk),
    .neg   (neg_r),
    .mag   (qround),
    .value (value),
    .sat   (sat)
  );

endmodule

`default_nettype wire

### rtl/fixed_point_alu_q24_8_top.sv
`default_nettype none

// Signed fixed-point ALU, DATA_WIDTH bits with FRAC_BITS fraction bits.
// Input channel: drive kind, operand_a and operand_b with start high; the item
// transfers at the rising edge where start is high and busy is low. busy is
// always low, so a new item may transfer in every cycle.
// Output channel: done is high for exactly one cycle per item, with result and
// the flags valid in that cycle; the transfer completes at the edge ending it.
// Results leave in the order items entered.
// done follows the transfer by the same delay for every operation. That delay
// is set by the divider pipeline, which resolves two quotient bits per stage;
// the other paths are delayed to match. Throughput is one item per cycle.
// The default format is Q24.8.
// Reset clears the valid bits of all stages, so nothing in flight is delivered
// and done stays low until a new item arrives. The receiver cannot stall, so
// the pipeline never holds.
module fixed_point_alu_q24_8_top #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire fpa_pkg::kind_t          kind,
  input  wire logic signed [DATA_WIDTH-1:0] operand_a,
  input  wire logic signed [DATA_WIDTH-1:0] operand_b,
  output logic                         busy,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] result,
  output logic                         a_less,
  output logic                         a_equal,
  output logic                         a_greater,
  output logic                         divide_by_zero,
  output logic                         saturated
);

  import fpa_pkg::*;

  localparam int DIV_STAGES = div_stages(DATA_WIDTH, FRAC_BITS);
  // Stages from the operand registers to the divider output.
  localparam int LAT = DIV_STAGES + 3;

  // Item data that bypasses the multiplier and divider.
  typedef struct packed {
    kind_t                 kind;
    logic [DATA_WIDTH-1:0] simple;
    cmp_flags_t            cmp;
    logic                  dz;
  } side_t;

  logic                         s1_valid;
  kind_t                        s1_kind;
  logic signed [DATA_WIDTH-1:0] s1_a;
  logic signed [DATA_WIDTH-1:0] s1_b;
  cmp_flags_t                   cmp;
  logic [DATA_WIDTH-1:0]        simple;
  logic [DATA_WIDTH-1:0]        mag_a;
  logic [DATA_WIDTH-1:0]        mag_b;
  logic                         neg;
  side_t                        side_in;
  side_t                        side       [LAT];
  logic                         side_valid [LAT];
  side_t                        side_out;
  logic [DATA_WIDTH-1:0]        mul_value;
  logic                         mul_sat;
  logic [DATA_WIDTH-1:0]        div_value;
  logic                         div_sat;
  logic [DATA_WIDTH-1:0]        result_next;
  logic                         sat_next;

  assign busy = 1'b0;

  // Input registers, loaded on every transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_kind <= kind;
    s1_a    <= operand_a;
    s1_b    <= operand_b;
  end

  // Compare flags, magnitudes and result sign.
  always_comb begin
    cmp.less    = s1_a < s1_b;
    cmp.equal   = s1_a == s1_b;
    cmp.greater = s1_a > s1_b;
    mag_a       = s1_a[DATA_WIDTH-1] ? (~s1_a + 1'b1) : s1_a;
    mag_b       = s1_b[DATA_WIDTH-1] ? (~s1_b + 1'b1) : s1_b;
    neg         = s1_a[DATA_WIDTH-1] ^ s1_b[DATA_WIDTH-1];
  end

  // Combinational operations; multiply, divide and unknown codes give zero here.
  always_comb begin
    unique case (s1_kind)
      KIND_ADD: simple = s1_a + s1_b;
      KIND_SUB: simple = s1_a - s1_b;
      KIND_MIN: simple = (cmp.less || cmp.equal) ? s1_a : s1_b;
      KIND_MAX: simple = (cmp.greater || cmp.equal) ? s1_a : s1_b;
      KIND_INC: simple = s1_a + 1'b1;
      KIND_DEC: simple = s1_a - 1'b1;
      KIND_I2F: simple = s1_a << FRAC_BITS;
      KIND_F2I: simple = s1_a >>> FRAC_BITS;
      default:  simple = '0;
    endcase
  end

  always_comb begin
    side_in.kind   = s1_kind;
    side_in.simple = simple;
    side_in.cmp    = cmp;
    side_in.dz     = (s1_kind == KIND_DIV) && (s1_b == '0);
  end

  // Side delay line, matched to the divider latency.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) begin
        side_valid[i] <= 1'b0;
      end
    end else begin
      side_valid[0] <= s1_valid;
      for (int i = 1; i < LAT; i++) begin
        side_valid[i] <= side_valid[i-1];
      end
    end
    side[0] <= side_in;
    for (int i = 1; i < LAT; i++) begin
      side[i] <= side[i-1];
    end
  end

  assign side_out = side[LAT-1];

  fpa_mul #(
    .DATA_WIDTH  (DATA_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .TAIL_STAGES (DIV_STAGES - 2)
  ) u_mul (
    .clk   (clk),
    .mag_a (mag_a),
    .mag_b (mag_b),
    .neg   (neg),
    .value (mul_value),
    .sat   (mul_sat)
  );

  fpa_div #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .mag_a (mag_a),
    .mag_b (mag_b),
    .neg   (neg),
    .value (div_value),
    .sat   (div_sat)
  );

  // Pick the result path by operation.
  always_comb begin
    case (side_out.kind)
      KIND_MUL: begin
        result_next = mul_value;
        sat_next    = mul_sat;
      end
      KIND_DIV: begin
        result_next = side_out.dz ? '0 : div_value;
        sat_next    = !side_out.dz && div_sat;
      end
      default: begin
        result_next = side_out.simple;
        sat_next    = 1'b0;
      end
    endcase
  end

  // Output register; done marks the one cycle of each transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side_valid[LAT-1];
    end
    result         <= result_next;
    a_less         <= side_out.cmp.less;
    a_equal        <= side_out.cmp.equal;
    a_greater      <= side_out.cmp.greater;
    divide_by_zero <= side_out.dz;
    saturated      <= sat_next;
  end

endmodule

`default_nettype wire
